/* rtl/core/h74sd_pkg.sv */
// shared types, constants and the codeword correction function
`default_nettype none

package h74sd_pkg;

  localparam int unsigned CwBits   = 7;
  localparam int unsigned NibBits  = 4;
  localparam int unsigned ByteBits = 8;
  localparam int unsigned CntBits  = 3;
  localparam int unsigned BufBits  = CwBits - 1;

  localparam logic [CntBits-1:0] MaxLeftover = CntBits'(CwBits - 1);

  typedef logic [ByteBits-1:0] byte_t;
  typedef logic [NibBits-1:0]  nib_t;
  typedef logic [CwBits-1:0]   cw_t;

  // up to two decoded bytes made by one request
  typedef struct packed {
    logic  has0;
    logic  has1;
    byte_t data0;
    logic  fin0;
    byte_t data1;
    logic  fin1;
  } bundle_t;

  typedef struct packed {
    logic [CntBits-1:0] bit_cnt;
    logic               nib_held;
  } front_stat_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

  // codeword p1 p2 d1 p3 d2 d3 d4 from bit 6 down to bit 0
  function automatic nib_t correct_nibble(input cw_t cw);
    logic       s1;
    logic       s2;
    logic       s3;
    logic [2:0] pos;
    cw_t        flip;
    cw_t        fixed;
    s1    = cw[6] ^ cw[4] ^ cw[2] ^ cw[0];
    s2    = cw[5] ^ cw[4] ^ cw[1] ^ cw[0];
    s3    = cw[3] ^ cw[2] ^ cw[1] ^ cw[0];
    pos   = {s3, s2, s1};
    flip  = (pos == 3'd0) ? '0 : (cw_t'(7'b1000000) >> (pos - 3'd1));
    fixed = cw ^ flip;
    return {fixed[4], fixed[2], fixed[1], fixed[0]};
  endfunction

endpackage

`default_nettype wire

/* rtl/core/h74sd_in_if.sv */
// input channel: coded stream bytes
`default_nettype none

interface h74sd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       final_byte;

  modport source (output valid, output code_byte, output final_byte, input ready);
  modport sink   (input valid, input code_byte, input final_byte, output ready);
endinterface

`default_nettype wire

/* rtl/core/h74sd_out_if.sv */
// result channel: decoded data bytes
`default_nettype none

interface h74sd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_out;

  modport source (output valid, output data_byte, output final_out, input ready);
  modport sink   (input valid, input data_byte, input final_out, output ready);
endinterface

`default_nettype wire

/* rtl/core/h74sd_front.sv */
// front end: bit gathering, codeword correction and nibble pairing
`default_nettype none

module h74sd_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  h74sd_pkg::byte_t      code_byte,
  input  logic                  final_byte,
  output h74sd_pkg::bundle_t    bundle,
  output h74sd_pkg::front_stat_t stat
);
  import h74sd_pkg::*;

  logic [CntBits-1:0] cnt_r, cnt_nxt;
  logic [BufBits-1:0] buf_r;
  nib_t               held_r, held_nxt;
  logic               held_v_r, held_v_nxt;

  logic [BufBits+ByteBits-1:0] stream;
  logic [BufBits+ByteBits-1:0] shifted;
  logic [CntBits:0]            shamt;
  logic                        two;
  nib_t                        nib0, nib1;
  logic                        first_v;
  byte_t                       first_b;
  logic                        flush;
  byte_t                       flush_b;

  always_comb begin
    // only bits below cnt_r of the buffer reach the first codeword
    stream  = {buf_r, code_byte};
    shamt   = {1'b0, cnt_r} + (CntBits+1)'(1);
    shifted = stream >> shamt;
    two     = (cnt_r == MaxLeftover);
    nib0    = correct_nibble(shifted[CwBits-1:0]);
    nib1    = correct_nibble(stream[CwBits-1:0]);

    first_v = held_v_r || two;
    first_b = held_v_r ? {held_r, nib0} : {nib0, nib1};

    held_v_nxt = held_v_r ? two : !two;
    held_nxt   = (held_v_r && two) ? nib1 : nib0;

    flush   = final_byte && held_v_nxt;
    flush_b = {held_nxt, {NibBits{1'b0}}};

    cnt_nxt = two ? '0 : shamt[CntBits-1:0];

    bundle.has0  = first_v || flush;
    bundle.has1  = first_v && flush;
    bundle.data0 = first_v ? first_b : flush_b;
    bundle.fin0  = final_byte && !(first_v && flush);
    bundle.data1 = flush_b;
    bundle.fin1  = final_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      held_v_r <= 1'b0;
      held_r   <= '0;
    end else if (accept) begin
      if (final_byte) begin
        cnt_r    <= '0;
        held_v_r <= 1'b0;
        held_r   <= '0;
      end else begin
        cnt_r    <= cnt_nxt;
        held_v_r <= held_v_nxt;
        held_r   <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buf_r <= code_byte[BufBits-1:0];
    end
  end

  assign stat.bit_cnt  = cnt_r;
  assign stat.nib_held = held_v_r;

endmodule

`default_nettype wire

/* rtl/core/h74sd_queue.sv */
// small queue of result bundles between front and back
`default_nettype none

module h74sd_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  h74sd_pkg::bundle_t     push_data,
  input  logic                   pop,
  output h74sd_pkg::bundle_t     head,
  output h74sd_pkg::queue_stat_t stat
);
  import h74sd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned LvlW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [LvlW-1:0] FullLvl = LvlW'(Depth);

  bundle_t         entries_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LvlW-1:0] level_r, level_nxt;
  logic            do_push, do_pop;

  always_comb begin
    do_push    = push && (level_r != FullLvl);
    do_pop     = pop && (level_r != '0);
    wr_ptr_nxt = do_push ? ((wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PtrW'(1)) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ((rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PtrW'(1)) : rd_ptr_r;
    level_nxt  = level_r;
    if (do_push && !do_pop) begin
      level_nxt = level_r + LvlW'(1);
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - LvlW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  assign head       = entries_r[rd_ptr_r];
  assign stat.empty = (level_r == '0);
  assign stat.full  = (level_r == FullLvl);

endmodule

`default_nettype wire

/* rtl/core/h74sd_back.sv */
// back end: unpacks bundles into the registered result channel
`default_nettype none

module h74sd_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  h74sd_pkg::bundle_t     head,
  input  h74sd_pkg::queue_stat_t q_stat,
  output logic                   pop,
  h74sd_out_if.source            out_chan
);
  import h74sd_pkg::*;

  logic  out_v_r, out_v_nxt;
  byte_t out_b_r, out_b_nxt;
  logic  out_f_r, out_f_nxt;
  logic  pend_v_r, pend_v_nxt;
  byte_t pend_b_r, pend_b_nxt;
  logic  pend_f_r, pend_f_nxt;
  logic  load;

  always_comb begin
    load       = !out_v_r || out_chan.ready;
    pop        = load && !pend_v_r && !q_stat.empty;
    out_v_nxt  = out_v_r;
    out_b_nxt  = out_b_r;
    out_f_nxt  = out_f_r;
    pend_v_nxt = pend_v_r;
    pend_b_nxt = pend_b_r;
    pend_f_nxt = pend_f_r;
    if (load) begin
      if (pend_v_r) begin
        out_v_nxt  = 1'b1;
        out_b_nxt  = pend_b_r;
        out_f_nxt  = pend_f_r;
        pend_v_nxt = 1'b0;
      end else if (!q_stat.empty) begin
        out_v_nxt  = 1'b1;
        out_b_nxt  = head.data0;
        out_f_nxt  = head.fin0;
        pend_v_nxt = head.has1;
        pend_b_nxt = head.data1;
        pend_f_nxt = head.fin1;
      end else begin
        out_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_b_r  <= out_b_nxt;
    out_f_r  <= out_f_nxt;
    pend_b_r <= pend_b_nxt;
    pend_f_r <= pend_f_nxt;
  end

  assign out_chan.valid     = out_v_r;
  assign out_chan.data_byte = out_b_r;
  assign out_chan.final_out = out_f_r;

endmodule

`default_nettype wire

/* rtl/core/hamming74_stream_decoder.sv */
// top level of the hamming(7,4) stream decoder
//
//  channel   dir  request payload                 handshake
//  in_chan   in   code_byte[7:0], final_byte      valid / ready
//  out_chan  out  data_byte[7:0], final_out       valid / ready
//
// one coded byte is taken per cycle while the bundle queue has room; it is decoded in the
// same cycle (one or two codewords) and queued as a bundle of up to two result bytes.
// results leave the output register at one per cycle while out_chan is ready, so a byte that makes two results
// holds the output port for both results in turn. reset (rst_n low,
// sync) clears the gathering state, the queue and the output register; no clearing pass.
// either side may stall without stopping the other until the queue fills.
`default_nettype none

module hamming74_stream_decoder #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  h74sd_in_if.sink    in_chan,
  h74sd_out_if.source out_chan
);
  import h74sd_pkg::*;

  bundle_t     bundle;   // what this request decodes to
  bundle_t     head;     // oldest queued bundle
  front_stat_t f_stat;
  queue_stat_t q_stat;
  logic        accept;
  logic        push;
  logic        pop;

  // front is only held back by a full queue
  assign in_chan.ready = !q_stat.full;
  assign accept        = in_chan.valid && in_chan.ready;
  // a request that completes no byte leaves nothing to queue
  assign push          = accept && bundle.has0;

  h74sd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .code_byte  (in_chan.code_byte),
    .final_byte (in_chan.final_byte),
    .bundle     (bundle),
    .stat       (f_stat)
  );

  h74sd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (bundle),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  h74sd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_chan (out_chan)
  );

`ifndef ASSERT_OFF
  // leftover bits never reach a whole codeword between requests
  a_leftover_short: assert property (@(posedge clk) disable iff (!rst_n)
    f_stat.bit_cnt <= MaxLeftover)
    else $error("leftover bit count above six");

  // the last byte of a message leaves the front clean
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_chan.final_byte) |=> (f_stat.bit_cnt == '0 && !f_stat.nib_held))
    else $error("state not cleared after final byte");

  // a bundle is never pushed into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("push into full queue");

  // a second result in a bundle always has a first beside it
  a_bundle_order: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && bundle.has1) |-> (bundle.has0 && bundle.fin1 == in_chan.final_byte))
    else $error("malformed result bundle");
`endif

endmodule

`default_nettype wire

/* tb/sv/hamming74_stream_decoder_tb.sv */
// testbench for the hamming(7,4) stream decoder: directed table, random messages, self-check
`timescale 1ns / 100ps

module hamming74_stream_decoder_tb;

  import h74sd_pkg::*;

  localparam int ClkPeriod     = 12;
  localparam int ResetCycles   = 5;
  localparam int MaxWait       = 14;
  localparam int RandomItems   = 1350;
  localparam int SettleCycles  = 20;
  localparam int TimeoutCycles = 400000;

  // a table row whose results come from the predictor rather than typed values
  localparam int Predicted = -1;

  // one decoded byte as it should leave the block
  typedef struct {
    byte_t data_byte;
    logic  final_out;
  } decoded_t;

  // one coded byte to send, with up to two typed-in results
  typedef struct {
    byte_t code;
    logic  fin;
    int    typed;
    byte_t d0;
    logic  f0;
    byte_t d1;
    logic  f1;
  } plan_row_t;

  localparam int NumPlanRows = 19;

  logic clk = 1'b0;
  logic rst_n;

  h74sd_in_if  in_ch ();
  h74sd_out_if out_ch ();

  hamming74_stream_decoder DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // directed part: every message starts from cleared state
  plan_row_t plan [NumPlanRows] = '{
    // single all-zero codeword, final: lone nibble flushed as 0x00
    '{8'h00, 1'b1, 1,         8'h00, 1'b1, 8'h00, 1'b0},
    // single all-ones codeword, final: flushed as high nibble only
    '{8'hFF, 1'b1, 1,         8'hF0, 1'b1, 8'h00, 1'b0},
    // clean pair 1111111 0000000, leftover bits dropped on final
    '{8'hFE, 1'b0, 0,         8'h00, 1'b0, 8'h00, 1'b0},
    '{8'h00, 1'b1, 1,         8'hF0, 1'b1, 8'h00, 1'b0},
    // data-bit error: d1 of the first codeword flipped
    '{8'hDE, 1'b0, 0,         8'h00, 1'b0, 8'h00, 1'b0},
    '{8'h00, 1'b1, 1,         8'hF0, 1'b1, 8'h00, 1'b0},
    // parity-bit error on p1, data untouched
    '{8'h81, 1'b0, 0,         8'h00, 1'b0, 8'h00, 1'b0},
    '{8'hFC, 1'b1, 1,         8'h0F, 1'b1, 8'h00, 1'b0},
    // parity-bit error on p3
    '{8'h11, 1'b0, 0,         8'h00, 1'b0, 8'h00, 1'b0},
    '{8'hFC, 1'b1, 1,         8'h0F, 1'b1, 8'h00, 1'b0},
    // seven bytes: the last one completes two codewords at once
    '{8'h12, 1'b0, Predicted, 8'h00, 1'b0, 8'h00, 1'b0},
    '{8'h34, 1'b0, Predicted, 8'h00, 1'b0, 8'h00, 1'b0},
    '{8'h56, 1'b0, Predicted, 8'h00, 1'b0, 8'h00, 1'b0},
    '{8'h78, 1'b0, Predicted, 8'h00, 1'b0, 8'h00, 1'b0},
    '{8'h9A, 1'b0, Predicted, 8'h00, 1'b0, 8'h00, 1'b0},
    '{8'hBC, 1'b0, Predicted, 8'h00, 1'b0, 8'h00, 1'b0},
    '{8'hDE, 1'b1, Predicted, 8'h00, 1'b0, 8'h00, 1'b0},
    // single-bit extremes
    '{8'h80, 1'b1, Predicted, 8'h00, 1'b0, 8'h00, 1'b0},
    '{8'h7F, 1'b1, Predicted, 8'h00, 1'b0, 8'h00, 1'b0}
  };

  // predictor state, cleared at the start of simulation and at the end of each message
  logic [13:0] leftover_bits;
  logic [3:0]  leftover_cnt = '0;
  nib_t        first_nib    = '0;
  logic        first_nib_ok = 1'b0;

  decoded_t fresh_bytes   [$];  // results of the request just predicted
  decoded_t awaited_bytes [$];  // results not yet seen at the output

  int  mismatch_count = 0;
  int  random_sent    = 0;
  bit  send_burst     = 1'b0;
  bit  recv_burst     = 1'b0;

  initial leftover_bits = '0;

  function automatic int draw_wait(input bit burst);
    return burst ? 0 : $urandom_range(0, MaxWait);
  endfunction

  // syndrome as the xor of the 1-based positions of all set bits
  function automatic nib_t correct_codeword(input cw_t cw);
    int   pos;
    int   syn;
    cw_t  fixed;
    syn   = 0;
    fixed = cw;
    for (pos = 1; pos <= CwBits; pos++) begin
      if (cw[CwBits - pos]) syn ^= pos;
    end
    if (syn != 0) fixed[CwBits - syn] = ~fixed[CwBits - syn];
    return {fixed[4], fixed[2], fixed[1], fixed[0]};
  endfunction

  // work out what one coded byte produces and advance the predictor
  function automatic void decode_request(input byte_t code, input logic fin);
    logic [22:0] acc;
    int unsigned have;
    cw_t         cw;
    nib_t        nib;
    fresh_bytes.delete();
    have = leftover_cnt;
    acc  = 23'(leftover_bits) & ((23'd1 << have) - 23'd1);
    acc  = (acc << ByteBits) | 23'(code);
    have = have + ByteBits;
    while (have >= CwBits) begin
      cw   = cw_t'(acc >> (have - CwBits));
      nib  = correct_codeword(cw);
      have = have - CwBits;
      acc  = acc & ((23'd1 << have) - 23'd1);
      if (first_nib_ok) begin
        fresh_bytes.push_back('{{first_nib, nib}, 1'b0});
        first_nib_ok = 1'b0;
        first_nib    = '0;
      end else begin
        first_nib    = nib;
        first_nib_ok = 1'b1;
      end
    end
    if (fin) begin
      // lone nibble goes out as the high half, then everything clears
      if (first_nib_ok) fresh_bytes.push_back('{{first_nib, 4'h0}, 1'b0});
      if (fresh_bytes.size() > 0) fresh_bytes[fresh_bytes.size() - 1].final_out = 1'b1;
      leftover_bits = '0;
      leftover_cnt  = '0;
      first_nib     = '0;
      first_nib_ok  = 1'b0;
    end else begin
      leftover_bits = acc[13:0];
      leftover_cnt  = have[3:0];
    end
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input plan_row_t row);
    int gap;
    int k;
    gap = draw_wait(send_burst);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.code_byte  <= row.code;
    in_ch.final_byte <= row.fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // request taken at this edge
    decode_request(row.code, row.fin);
    if (row.typed == Predicted) begin
      for (k = 0; k < fresh_bytes.size(); k++) awaited_bytes.push_back(fresh_bytes[k]);
    end else begin
      if (row.typed > 0) awaited_bytes.push_back('{row.d0, row.f0});
      if (row.typed > 1) awaited_bytes.push_back('{row.d1, row.f1});
    end
    @(negedge clk);
  endtask

  // hold off the sender until every predicted result has come out
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (awaited_bytes.size() != 0) @(negedge clk);
  endtask

  // one random message: mostly encoded nibbles with some corruption, some raw noise
  task automatic send_message();
    bit        stream [$];
    byte_t     msg    [$];
    plan_row_t row;
    int        kind;
    int        n_nib;
    int        n;
    int        j;
    int        flip_a;
    int        flip_b;
    nib_t      nib;
    cw_t       cw;
    byte_t     b;
    kind       = $urandom_range(0, 9);
    send_burst = ($urandom_range(0, 3) == 0);
    if (kind < 2) begin
      // raw bytes, final may land anywhere inside a codeword
      n = $urandom_range(1, 12);
      for (j = 0; j < n; j++) msg.push_back(byte_t'($urandom));
    end else begin
      n_nib = $urandom_range(1, 20);
      for (n = 0; n < n_nib; n++) begin
        nib = nib_t'($urandom);
        cw  = {nib[3] ^ nib[2] ^ nib[0], nib[3] ^ nib[1] ^ nib[0], nib[3],
               nib[2] ^ nib[1] ^ nib[0], nib[2], nib[1], nib[0]};
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
          cw[$urandom_range(0, CwBits - 1)] ^= 1'b1;
        end else if (kind == 4) begin
          // double error: miscorrected, still defined behaviour
          flip_a     = $urandom_range(0, CwBits - 1);
          flip_b     = (flip_a + $urandom_range(1, CwBits - 1)) % CwBits;
          cw[flip_a] ^= 1'b1;
          cw[flip_b] ^= 1'b1;
        end
        for (j = CwBits - 1; j >= 0; j--) stream.push_back(cw[j]);
      end
      // random padding up to a whole byte
      while (stream.size() % ByteBits != 0) stream.push_back(1'($urandom));
      for (n = 0; n < stream.size(); n += ByteBits) begin
        b = '0;
        for (j = 0; j < ByteBits; j++) b = {b[6:0], stream[n + j]};
        msg.push_back(b);
      end
    end
    for (n = 0; n < msg.size(); n++) begin
      row = '{msg[n], (n == msg.size() - 1), Predicted, 8'h00, 1'b0, 8'h00, 1'b0};
      send_request(row);
      random_sent++;
    end
  endtask

  // result side: random stalls between results, with occasional stall-free stretches
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) recv_burst = ~recv_burst;
      stall = draw_wait(recv_burst);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_bytes.size() == 0) begin
        $display("%0t: result with none awaited, data_byte=%h final_out=%b",
                 $time, out_ch.data_byte, out_ch.final_out);
        mismatch_count++;
      end else begin
        want = awaited_bytes.pop_front();
        if (out_ch.data_byte !== want.data_byte) begin
          $display("%0t: data_byte expected %h actual %h",
                   $time, want.data_byte, out_ch.data_byte);
          mismatch_count++;
        end
        if (out_ch.final_out !== want.final_out) begin
          $display("%0t: final_out expected %b actual %b",
                   $time, want.final_out, out_ch.final_out);
          mismatch_count++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int  idx;
    bit  mid_drain_done;
    mid_drain_done   = 1'b0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.code_byte  = '0;
    in_ch.final_byte = 1'b0;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (idx = 0; idx < NumPlanRows; idx++) send_request(plan[idx]);
    wait_for_drain();

    while (random_sent < RandomItems) begin
      send_message();
      // one full pause half way through the random part
      if (!mid_drain_done && random_sent >= RandomItems / 2) begin
        wait_for_drain();
        mid_drain_done = 1'b1;
      end
    end

    wait_for_drain();
    repeat (SettleCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog against a hung handshake
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("tb: failure");
    $finish;
  end

endmodule
